/* sv/fdmd_pkg.sv */
// ----------------------------------------------------------------------------
// fdmd_pkg: shared types and constants of the frame difference motion detector
// Frame geometry, register codes, beat payloads and pipeline records.
// ----------------------------------------------------------------------------
package fdmd_pkg;

  localparam int IMAGE_WIDTH  = 320;
  localparam int IMAGE_HEIGHT = 240;
  localparam int FRAME_PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W       = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  localparam int PIX_W        = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [PIX_W-1:0] DEFAULT_THRESHOLD = 8'd20;
  localparam logic [PIX_W-1:0] WHITE             = 8'd255;

  // (r+g+b)/3 as (sum * 683) >> 11, exact for sums up to 765
  localparam int SUM_W      = PIX_W + 2;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int PROD_W     = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 2'd0,
    REG_THRESHOLD   = 2'd1,
    REG_GRAY_SOURCE = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_PREV       = 1'b0,
    MODE_BACKGROUND = 1'b1
  } mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] luma_in;
    logic             start_of_frame;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             motion;
    logic [PIX_W-1:0] difference;
    logic [PIX_W-1:0] gray_out;
  } out_t;

  // Frame store write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } wr_t;

  // Pixel record handed from the front end to the compare stage
  typedef struct packed {
    logic [PIX_W-1:0]  gray;
    logic [ADDR_W-1:0] addr;
    logic              write;
    logic              capture;
    mode_t             mode;
    logic              fwd;
    logic [PIX_W-1:0]  fwd_data;
  } item_t;

endpackage

/* sv/frame_difference_motion_detector_unit.sv */
// ----------------------------------------------------------------------------
// frame_difference_motion_detector_unit: frame differencing motion detector
// Gray conversion, full-frame reference store, per-pixel motion decision.
// ----------------------------------------------------------------------------
// One pixel beat is taken per clock while in_ready is high, and each gives one
// result beat. The pipeline is the frame store read, registered alongside the
// pixel record, followed by the compare stage and the output register; the
// single read and single write port of the frame store set the rate of one
// pixel per cycle, with the compare stage forwarding its own write to a pixel
// at the same address. After reset the block zeroes the frame store, one entry
// per cycle, over all IMAGE_WIDTH*IMAGE_HEIGHT entries (76800 at 320x240), and
// holds in_ready low meanwhile; register writes are taken at any time. Any
// write to one of the three registers restarts background capture.
module frame_difference_motion_detector_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fdmd_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fdmd_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [fdmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdmd_pkg::CFG_DATA_W-1:0] cfg_data
);

  import fdmd_pkg::*;

  mode_t             mode;
  logic [PIX_W-1:0]  threshold;
  logic              gray_source;
  logic              cfg_clear;

  logic              back_ready;
  wr_t               back_wr;
  wr_t               ram_wr;
  logic              item_valid;
  item_t             item;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rd_data;

  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_MODE, REG_THRESHOLD, REG_GRAY_SOURCE: cfg_clear = cfg_we;
      default:                                  cfg_clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PREV;
      threshold   <= DEFAULT_THRESHOLD;
      gray_source <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:        mode        <= mode_t'(cfg_data[0]);
        REG_THRESHOLD:   threshold   <= cfg_data[PIX_W-1:0];
        REG_GRAY_SOURCE: gray_source <= cfg_data[0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  fdmd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .mode        (mode),
    .gray_source (gray_source),
    .cfg_clear   (cfg_clear),
    .back_ready  (back_ready),
    .back_wr     (back_wr),
    .item_valid  (item_valid),
    .item        (item),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .ram_wr      (ram_wr)
  );

  fdmd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FRAME_PIXELS),
    .AW    (ADDR_W)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  fdmd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .rd_data    (rd_data),
    .threshold  (threshold),
    .ready      (back_ready),
    .wr         (back_wr),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* sv/fdmd_ram.sv */
// ----------------------------------------------------------------------------
// fdmd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fdmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/fdmd_front.sv */
// ----------------------------------------------------------------------------
// fdmd_front: input side of the motion detector
// Gray conversion, pixel address sequencing, capture flags, store clearing.
// ----------------------------------------------------------------------------
module fdmd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fdmd_pkg::in_t                in_data,
  input  fdmd_pkg::mode_t              mode,
  input  logic                         gray_source,
  input  logic                         cfg_clear,
  input  logic                         back_ready,
  input  fdmd_pkg::wr_t                back_wr,
  output logic                         item_valid,
  output fdmd_pkg::item_t              item,
  output logic                         rd_en,
  output logic [fdmd_pkg::ADDR_W-1:0]  rd_addr,
  output fdmd_pkg::wr_t                ram_wr
);

  import fdmd_pkg::*;

  logic [ADDR_W-1:0] pixel_address;
  logic              background_valid;
  logic              frame_seen;
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  logic              accept;
  logic [ADDR_W-1:0] addr_cur;
  logic [ADDR_W:0]   addr_inc;
  logic              wrap;
  logic [ADDR_W-1:0] pixel_address_next;
  logic              bg_sof;
  logic              frame_seen_next;
  logic              background_valid_next;
  logic              capture;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  gray;

  assign in_ready = !clearing && back_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    sum  = SUM_W'(in_data.red) + SUM_W'(in_data.green) + SUM_W'(in_data.blue);
    prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
    gray = gray_source ? in_data.luma_in : prod[DIV3_SHIFT +: PIX_W];
  end

  always_comb begin
    addr_cur = in_data.start_of_frame ? '0 : pixel_address;
    if ((ADDR_W+1)'(addr_cur) >= (ADDR_W+1)'(FRAME_PIXELS)) begin
      addr_cur = '0;
    end
    // start of frame closes a capture that has already seen address zero
    bg_sof = background_valid ||
             (mode == MODE_BACKGROUND && frame_seen && in_data.start_of_frame);
    frame_seen_next = frame_seen || (addr_cur == '0);
    capture  = (mode == MODE_BACKGROUND) && !bg_sof;
    addr_inc = (ADDR_W+1)'(addr_cur) + (ADDR_W+1)'(1);
    wrap     = addr_inc >= (ADDR_W+1)'(FRAME_PIXELS);
    pixel_address_next    = wrap ? '0 : addr_inc[ADDR_W-1:0];
    background_valid_next = bg_sof ||
                            (wrap && mode == MODE_BACKGROUND && frame_seen_next);
  end

  always_comb begin
    item.gray     = gray;
    item.addr     = addr_cur;
    item.write    = (mode == MODE_PREV) || capture;
    item.capture  = capture;
    item.mode     = mode;
    // the write leaving the compare stage this cycle is not yet in the store
    item.fwd      = back_wr.en && (back_wr.addr == addr_cur);
    item.fwd_data = back_wr.data;
  end

  assign item_valid = accept;
  assign rd_en      = accept;
  assign rd_addr    = addr_cur;

  always_comb begin
    if (clearing) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = clr_addr;
      ram_wr.data = '0;
    end else begin
      ram_wr = back_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_address    <= '0;
      background_valid <= 1'b0;
      frame_seen       <= 1'b0;
    end else begin
      if (accept) begin
        pixel_address    <= pixel_address_next;
        background_valid <= background_valid_next;
        frame_seen       <= frame_seen_next;
      end
      if (cfg_clear) begin
        background_valid <= 1'b0;
        frame_seen       <= 1'b0;
      end
    end
  end

  // Zero the frame store one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if ((ADDR_W+1)'(clr_addr) == (ADDR_W+1)'(FRAME_PIXELS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

endmodule

/* sv/fdmd_back.sv */
// ----------------------------------------------------------------------------
// fdmd_back: compare stage and output register
// Absolute difference against the stored pixel, threshold, write-back.
// ----------------------------------------------------------------------------
module fdmd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  fdmd_pkg::item_t             item,
  input  logic [fdmd_pkg::PIX_W-1:0]  rd_data,
  input  logic [fdmd_pkg::PIX_W-1:0]  threshold,
  output logic                        ready,
  output fdmd_pkg::wr_t               wr,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fdmd_pkg::out_t              out_data
);

  import fdmd_pkg::*;

  logic             s1_valid;
  item_t            s1;
  logic             advance;
  logic [PIX_W-1:0] ref_pix;
  logic [PIX_W-1:0] diff;
  logic             motion;
  out_t             result;

  assign advance = s1_valid && (!out_valid || out_ready);
  assign ready   = !s1_valid || !out_valid || out_ready;

  always_comb begin
    ref_pix = s1.fwd ? s1.fwd_data : rd_data;
    diff    = (s1.gray > ref_pix) ? (s1.gray - ref_pix) : (ref_pix - s1.gray);
    motion  = diff > threshold;
    result.gray_out = s1.gray;
    if (s1.capture) begin
      result.out_pixel  = '0;
      result.motion     = 1'b0;
      result.difference = '0;
    end else begin
      result.motion     = motion;
      result.difference = diff;
      if (motion) begin
        result.out_pixel = WHITE;
      end else if (s1.mode == MODE_PREV) begin
        result.out_pixel = s1.gray;
      end else begin
        result.out_pixel = '0;
      end
    end
  end

  always_comb begin
    wr.en   = advance && s1.write;
    wr.addr = s1.addr;
    wr.data = s1.gray;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      s1 <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule
